/* sv/bb3_pkg.sv */
// Shared types and constants for the 3x3 edge-aware box blur.
// No dependencies; compiled first.
package bb3_pkg;

  // Depth of the job queue between front and back
  localparam int QDEPTH = 4;
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // One classified pixel: window snapshot plus border flags and emit mask
  typedef struct packed {
    rgb_t [2:0][2:0] win;
    logic            row_ge1;
    logic            row_ge2;
    logic            col_ge1;
    logic            col_ge2;
    logic [3:0]      emit;
    logic            frame_last;
    logic [11:0]     row;
    logic [9:0]      col;
  } job_t;

  // Queue status toward front and back
  typedef struct packed {
    logic [QCW-1:0] count;
    logic           empty;
  } qstat_t;

endpackage

/* sv/bb3_if.sv */
// Channel interfaces: pixel input, blurred result output, configuration write.
// Depends on nothing; compiled after bb3_pkg.
interface bb3_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  modport source(output valid, red_in, green_in, blue_in, input ready);
  modport sink(input valid, red_in, green_in, blue_in, output ready);
endinterface

interface bb3_res_if;
  logic        valid;
  logic        ready;
  logic [11:0] out_row;
  logic [9:0]  out_col;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic        run_end;
  logic        frame_end;
  modport source(output valid, out_row, out_col, red_out, green_out, blue_out,
                 run_end, frame_end, input ready);
  modport sink(input valid, out_row, out_col, red_out, green_out, blue_out,
               run_end, frame_end, output ready);
endinterface

interface bb3_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [12:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* sv/bb3_front.sv */
// Front end: size registers, pixel accept, line memory, 3x3 window, job build.
// Depends on bb3_pkg and bb3_if.
module bb3_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  bb3_pix_if.sink         pix_i,
  bb3_cfg_if.sink         cfg_i,
  input  bb3_pkg::qstat_t qstat_i,
  output logic            push_o,
  output bb3_pkg::job_t   push_data_o
);
  import bb3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [10:0] width_q;
  logic [12:0] height_q;
  logic [13:0] w_eff;
  logic [16:0] h_eff;

  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic          last_col, last_row, accept;

  logic [47:0] line_mem [MAX_WIDTH];
  logic [47:0] rd_q, fwd_data_q, line_rd, wr_data;
  logic        fwd_q;

  logic          s1_valid_q;
  rgb_t          s1_pix_q;
  logic [CW-1:0] s1_idx_q;
  logic [11:0]   s1_row_q;
  logic [9:0]    s1_col_q;
  logic          s1_rge1_q, s1_rge2_q, s1_cge1_q, s1_cge2_q, s1_lc_q, s1_lr_q;

  rgb_t [2:0][2:0] win_q, win_d;

  // Write size registers; always ready
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd640;
      height_q <= 13'd480;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_WIDTH:  width_q  <= cfg_i.data[10:0];
        CFG_HEIGHT: height_q <= cfg_i.data;
        default:    ;
      endcase
    end
  end

  // Clamp sizes to 1..MAX
  always_comb begin
    if (width_q == 11'd0) w_eff = 14'd1;
    else if (14'(width_q) > 14'(MAX_WIDTH)) w_eff = 14'(MAX_WIDTH);
    else w_eff = 14'(width_q);
    if (height_q == 13'd0) h_eff = 17'd1;
    else if (17'(height_q) > 17'(MAX_HEIGHT)) h_eff = 17'(MAX_HEIGHT);
    else h_eff = 17'(height_q);
  end

  assign last_col = 14'(col_q) >= (w_eff - 14'd1);
  assign last_row = 17'(row_q) >= (h_eff - 17'd1);

  // Hold off input while the queue could not take this job and the one in flight
  assign pix_i.ready = (4'(qstat_i.count) + 4'(s1_valid_q)) < 4'(QDEPTH);
  assign accept      = pix_i.valid && pix_i.ready;

  // Advance raster position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // Line memory: {older row, newer row} per column, registered read
  assign line_rd = fwd_q ? fwd_data_q : rd_q;
  assign wr_data = {line_rd[23:0], s1_pix_q};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= line_mem[col_q];
    end
    if (s1_valid_q) begin
      line_mem[s1_idx_q] <= wr_data;
    end
  end

  // Forward the write of the job in flight when it hits the address being read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fwd_q      <= s1_valid_q && (s1_idx_q == col_q);
      fwd_data_q <= wr_data;
      s1_pix_q   <= '{r: pix_i.red_in, g: pix_i.green_in, b: pix_i.blue_in};
      s1_idx_q   <= col_q;
      s1_row_q   <= 12'(row_q);
      s1_col_q   <= 10'(col_q);
      s1_rge1_q  <= 17'(row_q) >= 17'd1;
      s1_rge2_q  <= 17'(row_q) >= 17'd2;
      s1_cge1_q  <= 14'(col_q) >= 14'd1;
      s1_cge2_q  <= 14'(col_q) >= 14'd2;
      s1_lc_q    <= last_col;
      s1_lr_q    <= last_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  // Shift the window and load the new column
  always_comb begin
    win_d = win_q;
    for (int r = 0; r < 3; r++) begin
      win_d[r][0] = win_q[r][1];
      win_d[r][1] = win_q[r][2];
    end
    win_d[0][2] = line_rd[47:24];
    win_d[1][2] = line_rd[23:0];
    win_d[2][2] = s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_valid_q) begin
      win_q <= win_d;
    end
  end

  // Build the job
  always_comb begin
    push_data_o.win        = win_d;
    push_data_o.row_ge1    = s1_rge1_q;
    push_data_o.row_ge2    = s1_rge2_q;
    push_data_o.col_ge1    = s1_cge1_q;
    push_data_o.col_ge2    = s1_cge2_q;
    push_data_o.emit[0]    = s1_rge1_q && s1_cge1_q;
    push_data_o.emit[1]    = s1_rge1_q && s1_lc_q;
    push_data_o.emit[2]    = s1_lr_q && s1_cge1_q;
    push_data_o.emit[3]    = s1_lr_q && s1_lc_q;
    push_data_o.frame_last = s1_lr_q && s1_lc_q;
    push_data_o.row        = s1_row_q;
    push_data_o.col        = s1_col_q;
  end
  assign push_o = s1_valid_q;

endmodule

/* sv/bb3_queue.sv */
// Short job queue between front and back.
// Depends on bb3_pkg.
module bb3_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bb3_pkg::job_t   push_data_i,
  input  logic            pop_i,
  output bb3_pkg::job_t   head_o,
  output bb3_pkg::qstat_t stat_o
);
  import bb3_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  job_t           mem_q [QDEPTH];
  logic [PW-1:0]  wptr_q, rptr_q;
  logic [QCW-1:0] count_q;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + PW'(1);
      if (pop_i)  rptr_q <= rptr_q + PW'(1);
      count_q <= count_q + QCW'(push_i) - QCW'(pop_i);
    end
  end

  assign head_o       = mem_q[rptr_q];
  assign stat_o.count = count_q;
  assign stat_o.empty = (count_q == '0);

endmodule

/* sv/bb3_back.sv */
// Back end: walks each job's results, sums the window, divides, drives output.
// Depends on bb3_pkg and bb3_if.
module bb3_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bb3_pkg::job_t   head_i,
  input  bb3_pkg::qstat_t qstat_i,
  output logic            pop_o,
  bb3_res_if.source       res_o
);
  import bb3_pkg::*;

  // Reciprocal of 2n scaled by 2^20, rounded up; exact for numerators < 4600
  function automatic logic [19:0] recip(input logic [3:0] n);
    logic [19:0] m;
    case (n)
      4'd1:    m = 20'd524288;
      4'd2:    m = 20'd262144;
      4'd3:    m = 20'd174763;
      4'd4:    m = 20'd131072;
      4'd6:    m = 20'd87382;
      4'd9:    m = 20'd58255;
      default: m = 20'd0;
    endcase
    return m;
  endfunction

  logic        adv, have, emit_now;
  logic [3:0]  done_q, cur, pick, nxt;
  logic [1:0]  kind;
  logic [2:0]  ruse, cuse;
  logic [1:0]  nr, nc;
  logic [3:0]  n;
  logic [11:0] sum [3];
  logic [9:0]  rsum [3][3];
  logic [11:0] pos_row;
  logic [9:0]  pos_col;

  logic        sv_q;
  logic [11:0] sum_q [3];
  logic [3:0]  n_q;
  logic [11:0] row_q;
  logic [9:0]  col_q;
  logic        run_q, frame_q;

  logic        out_valid_q;
  logic [12:0] num [3];
  logic [32:0] prod [3];

  assign adv  = !out_valid_q || res_o.ready;
  assign have = !qstat_i.empty;
  assign cur  = head_i.emit & ~done_q;

  // Pick the next pending result of the head job
  always_comb begin
    kind = 2'd0;
    if (cur[0])      kind = 2'd0;
    else if (cur[1]) kind = 2'd1;
    else if (cur[2]) kind = 2'd2;
    else             kind = 2'd3;
    pick = 4'(1) << kind;
  end
  assign nxt      = cur & ~pick;
  assign emit_now = adv && have && (cur != 4'd0);
  assign pop_o    = adv && have && (nxt == 4'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= '0;
    end else if (adv && have) begin
      done_q <= (nxt == 4'd0) ? 4'd0 : (done_q | pick);
    end
  end

  // Window rows and columns that lie inside the image for this result
  assign ruse = {1'b1, head_i.row_ge1, !kind[1] && head_i.row_ge2};
  assign cuse = {1'b1, head_i.col_ge1, !kind[0] && head_i.col_ge2};
  assign nr   = 2'($countones(ruse));
  assign nc   = 2'($countones(cuse));
  assign n    = 4'(nr) * 4'(nc);

  // Sum per channel: rows first, then across rows
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int ch = 0; ch < 3; ch++) rsum[r][ch] = '0;
      for (int c = 0; c < 3; c++) begin
        if (ruse[r] && cuse[c]) begin
          rsum[r][0] = rsum[r][0] + 10'(head_i.win[r][c].r);
          rsum[r][1] = rsum[r][1] + 10'(head_i.win[r][c].g);
          rsum[r][2] = rsum[r][2] + 10'(head_i.win[r][c].b);
        end
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = 12'(rsum[0][ch]) + 12'(rsum[1][ch]) + 12'(rsum[2][ch]);
    end
  end

  assign pos_row = kind[1] ? head_i.row : head_i.row - 12'd1;
  assign pos_col = kind[0] ? head_i.col : head_i.col - 10'd1;

  // Sum stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= 1'b0;
    end else if (adv) begin
      sv_q <= emit_now;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_now) begin
      sum_q   <= sum;
      n_q     <= n;
      row_q   <= pos_row;
      col_q   <= pos_col;
      run_q   <= (nxt == 4'd0);
      frame_q <= (nxt == 4'd0) && head_i.frame_last;
    end
  end

  // Rounded mean: (2*sum + n) / (2n) by reciprocal multiply
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      num[ch]  = {sum_q[ch], 1'b0} + 13'(n_q);
      prod[ch] = 33'(num[ch]) * 33'(recip(n_q));
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= sv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && sv_q) begin
      res_o.out_row   <= row_q;
      res_o.out_col   <= col_q;
      res_o.red_out   <= prod[0][27:20];
      res_o.green_out <= prod[1][27:20];
      res_o.blue_out  <= prod[2][27:20];
      res_o.run_end   <= run_q;
      res_o.frame_end <= frame_q;
    end
  end
  assign res_o.valid = out_valid_q;

  a_frame_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_o.frame_end |-> res_o.run_end)
    else $error("frame_end without run_end");
  a_n_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q |-> (n_q != 4'd0) && (n_q <= 4'd9))
    else $error("bad neighbor count");
  a_pop_avail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !qstat_i.empty)
    else $error("pop from empty queue");
  a_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q && adv |=> out_valid_q)
    else $error("result lost between stages");

endmodule

/* sv/box_blur_3x3_edge_aware_unit.sv */
// 3x3 edge-aware box blur over RGB raster frames.
// Throughput: one pixel per cycle; the back end gives one result per cycle while
// out_o is ready, so last-column and last-row pixels (up to 4 results) fill the
// 4-entry job queue. Pixel to result: s1 stage, queue, sum stage, output register.
// Reset: counters, window cleared, size 640x480; line memory is not cleared.
// Depends on bb3_pkg, bb3_if, bb3_front, bb3_queue, bb3_back.
module box_blur_3x3_edge_aware_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bb3_pix_if.sink   in_i,
  bb3_cfg_if.sink   cfg_i,
  bb3_res_if.source out_o
);
  import bb3_pkg::*;

  logic   push, pop;
  job_t   push_data, head;
  qstat_t qstat;

  bb3_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (in_i),
    .cfg_i      (cfg_i),
    .qstat_i    (qstat),
    .push_o     (push),
    .push_data_o(push_data)
  );

  bb3_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (qstat)
  );

  bb3_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .qstat_i(qstat),
    .pop_o  (pop),
    .res_o  (out_o)
  );

endmodule
